[rtl/osp_pkg.sv]
`timescale 1ns / 1ps

package osp_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int RATE_W          = 24;
  localparam int TARGET_W        = 15;
  localparam int GAIN_W          = 32;
  localparam int FRAC_W          = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = RATE_W;
  localparam int DEF_MAX_SAMPLES = 16384;
  localparam int DIV_STEPS       = TARGET_W + FRAC_W;
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

  localparam logic [GAIN_W-1:0]   UNITY_GAIN   = GAIN_W'(1) << FRAC_W;
  localparam logic [RATE_W-1:0]   RATE_RESET   = RATE_W'(1) << FRAC_W;
  localparam logic [TARGET_W-1:0] TARGET_RESET = {TARGET_W{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_REWIND = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE   = 2'd0,
    CFG_NORM   = 2'd1,
    CFG_TARGET = 2'd2
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_MUL,
    ST_SAT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]                 operation;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       done_res;
  } out_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_step;
    logic mul;
    logic sat;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_needed;
    logic read_hit;
  } dp_stat_t;

endpackage

[rtl/one_shot_sample_player_core.sv]
`timescale 1ns / 1ps

// One-shot sample player. Raise start_i with an item on in_i while busy_o is low; every item
// returns exactly one result on res_o, marked by res_valid_o for a single cycle, and the
// receiver cannot hold it off, so it must take each result in that cycle. Clear and load
// items, and ticks that need no new sample, pass through an execute and a response state;
// ticks that fetch a sample do a registered store read, then a registered multiply and a
// saturation step; a rewind with normalizing on and a nonzero peak runs the bit-serial gain
// divider, one quotient bit per cycle. Write configuration only while the block is idle;
// the sample store has no reset.
module one_shot_sample_player_core #(
  parameter int MAX_SAMPLES = osp_pkg::DEF_MAX_SAMPLES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  osp_pkg::in_t                      in_i,
  output logic                              res_valid_o,
  output osp_pkg::out_t                     res_o,
  input  logic                              cfg_we_i,
  input  logic [osp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [osp_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  osp_pkg::ctrl_cmd_t cmd;
  osp_pkg::dp_stat_t  stat;

  osp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o)
  );

  osp_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_i       (in_i),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

endmodule

[rtl/osp_ctrl.sv]
`timescale 1ns / 1ps

module osp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  osp_pkg::dp_stat_t    stat_i,
  output osp_pkg::ctrl_cmd_t   cmd_o,
  output logic                 busy_o,
  output logic                 res_valid_o
);

  osp_pkg::state_e                 state_q, state_d;
  logic [osp_pkg::DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= osp_pkg::ST_IDLE;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    div_cnt_d   = '0;
    cmd_o       = '0;
    busy_o      = 1'b1;
    res_valid_o = 1'b0;
    unique case (state_q)
      osp_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = osp_pkg::ST_EXEC;
        end
      end
      osp_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.div_needed) begin
          state_d = osp_pkg::ST_DIV;
        end else if (stat_i.read_hit) begin
          state_d = osp_pkg::ST_MUL;
        end else begin
          state_d = osp_pkg::ST_RESP;
        end
      end
      osp_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (div_cnt_q == osp_pkg::DIV_CNT_W'(osp_pkg::DIV_STEPS - 1)) begin
          state_d = osp_pkg::ST_RESP;
        end else begin
          div_cnt_d = div_cnt_q + 1'b1;
        end
      end
      osp_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = osp_pkg::ST_SAT;
      end
      osp_pkg::ST_SAT: begin
        cmd_o.sat = 1'b1;
        state_d   = osp_pkg::ST_RESP;
      end
      osp_pkg::ST_RESP: begin
        res_valid_o = 1'b1;
        state_d     = osp_pkg::ST_IDLE;
      end
      default: begin
        state_d = osp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/osp_dp.sv]
`timescale 1ns / 1ps

module osp_dp #(
  parameter int MAX_SAMPLES = osp_pkg::DEF_MAX_SAMPLES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  osp_pkg::ctrl_cmd_t                cmd_i,
  output osp_pkg::dp_stat_t                 stat_o,
  input  osp_pkg::in_t                      in_i,
  output osp_pkg::out_t                     res_o,
  input  logic                              cfg_we_i,
  input  logic [osp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [osp_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int SW  = osp_pkg::SAMPLE_W;
  localparam int FW  = osp_pkg::FRAC_W;
  localparam int GW  = osp_pkg::GAIN_W;
  localparam int TW  = osp_pkg::TARGET_W;
  localparam int RW  = osp_pkg::RATE_W;
  localparam int DW  = osp_pkg::DIV_STEPS;
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int PW  = ((CW + FW > RW) ? CW + FW : RW) + 1;
  localparam int IW  = PW - FW;
  localparam int MW  = SW + GW + 1;
  localparam int QW  = MW - FW;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);
  localparam logic signed [QW-1:0] SAT_MAX = QW'((1 << (SW - 1)) - 1);
  localparam logic signed [QW-1:0] SAT_MIN = -SAT_MAX - QW'(1);

  logic signed [SW-1:0] mem [MAX_SAMPLES];

  logic [RW-1:0]        rate_q;
  logic                 norm_q;
  logic [TW-1:0]        target_q;
  logic [CW-1:0]        count_q;
  logic [SW-1:0]        peak_q;
  logic [GW-1:0]        gain_q;
  logic [PW-1:0]        pos_q;
  logic [CW-1:0]        last_q;
  logic                 done_q;
  logic signed [SW-1:0] held_q;

  osp_pkg::op_e         op_q;
  logic signed [SW-1:0] smp_q;
  logic signed [SW-1:0] rd_data_q;
  logic signed [MW-1:0] prod_q;
  logic [DW-1:0]        num_q;
  logic [SW-1:0]        rem_q;

  logic [PW-1:0]        pos_sum;
  logic [PW-1:0]        end_pos;
  logic [PW-1:0]        stuck_pos;
  logic                 at_end;
  logic [IW-1:0]        idx;
  logic [AW-1:0]        rd_addr;
  logic                 tick_live;
  logic [SW:0]          smp_ext;
  logic [SW-1:0]        mag;
  logic [SW:0]          rem_sh;
  logic                 div_ge;
  logic [SW:0]          rem_sub;
  logic signed [QW-1:0] scaled;
  logic signed [SW-1:0] sat_val;

  always_comb begin
    pos_sum   = pos_q + PW'(rate_q);
    end_pos   = PW'({count_q, {FW{1'b0}}});
    stuck_pos = (count_q == '0) ? '0 : PW'({count_q - 1'b1, {FW{1'b0}}});
    at_end    = pos_sum >= end_pos;
    idx       = pos_sum[PW-1:FW];
    rd_addr   = AW'(idx - 1'b1);
    tick_live = (op_q == osp_pkg::OP_TICK) && !done_q;

    stat_o.read_hit   = tick_live && !at_end && (idx > IW'(last_q));
    stat_o.div_needed = (op_q == osp_pkg::OP_REWIND) && norm_q && (peak_q != '0);

    smp_ext = {smp_q[SW-1], smp_q};
    mag     = smp_q[SW-1] ? SW'(~smp_ext + 1'b1) : smp_q;

    rem_sh  = {rem_q, num_q[DW-1]};
    div_ge  = rem_sh >= {1'b0, peak_q};
    rem_sub = rem_sh - {1'b0, peak_q};

    scaled = QW'(prod_q >>> FW);
    if (scaled > SAT_MAX) begin
      sat_val = SW'(SAT_MAX);
    end else if (scaled < SAT_MIN) begin
      sat_val = SW'(SAT_MIN);
    end else begin
      sat_val = SW'(scaled);
    end

    res_o.out_sample = held_q;
    res_o.done_res   = done_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= osp_pkg::RATE_RESET;
      norm_q   <= 1'b0;
      target_q <= osp_pkg::TARGET_RESET;
      count_q  <= '0;
      peak_q   <= '0;
      gain_q   <= osp_pkg::UNITY_GAIN;
      pos_q    <= '0;
      last_q   <= '0;
      done_q   <= 1'b0;
      held_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          osp_pkg::CFG_RATE:   rate_q   <= cfg_data_i[RW-1:0];
          osp_pkg::CFG_NORM:   norm_q   <= cfg_data_i[0];
          osp_pkg::CFG_TARGET: target_q <= cfg_data_i[TW-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.exec) begin
        unique case (op_q)
          osp_pkg::OP_CLEAR: begin
            count_q <= '0;
            peak_q  <= '0;
          end
          osp_pkg::OP_LOAD: begin
            if (count_q < MAX_CNT) begin
              count_q <= count_q + 1'b1;
              if (mag > peak_q) begin
                peak_q <= mag;
              end
            end
          end
          osp_pkg::OP_REWIND: begin
            pos_q  <= '0;
            last_q <= '0;
            done_q <= 1'b0;
            held_q <= '0;
            gain_q <= norm_q ? '0 : osp_pkg::UNITY_GAIN;
          end
          osp_pkg::OP_TICK: begin
            if (tick_live) begin
              if (at_end) begin
                pos_q  <= stuck_pos;
                done_q <= 1'b1;
              end else begin
                pos_q <= pos_sum;
                if (stat_o.read_hit) begin
                  last_q <= CW'(idx);
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.div_step) begin
        gain_q <= {gain_q[GW-2:0], div_ge};
      end
      if (cmd_i.sat) begin
        held_q <= sat_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= osp_pkg::op_e'(in_i.operation);
      smp_q <= in_i.sample_in;
    end
    if (cmd_i.exec && (op_q == osp_pkg::OP_LOAD) && (count_q < MAX_CNT)) begin
      mem[count_q[AW-1:0]] <= smp_q;
    end
    if (cmd_i.exec && stat_o.read_hit) begin
      rd_data_q <= mem[rd_addr];
    end
    if (cmd_i.exec) begin
      num_q <= {target_q, {FW{1'b0}}};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[DW-2:0], 1'b0};
      rem_q <= div_ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= MW'(rd_data_q * $signed({1'b0, gain_q}));
    end
  end

endmodule

[tb/tb_one_shot_sample_player_core.sv]
`timescale 1ns / 1ps

module tb_one_shot_sample_player_core;

  localparam int MAX_SAMPLES    = osp_pkg::DEF_MAX_SAMPLES;
  localparam int RAND_ITEMS     = 330;
  localparam int CALM_ITEMS     = 60;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    bit                             is_cfg;
    bit                             calm;
    osp_pkg::cfg_e                  idx;
    logic [osp_pkg::CFG_DATA_W-1:0] data;
    osp_pkg::in_t                   item;
  } player_cmd_t;

  logic                           clk_i      = 1'b0;
  logic                           rst_ni     = 1'b0;
  logic                           start_i    = 1'b0;
  logic                           busy_o;
  osp_pkg::in_t                   in_i       = '0;
  logic                           res_valid_o;
  osp_pkg::out_t                  res_o;
  logic                           cfg_we_i   = 1'b0;
  logic [osp_pkg::CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [osp_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  one_shot_sample_player_core #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // expected player state
  logic [osp_pkg::RATE_W-1:0]          rate_r   = osp_pkg::RATE_RESET;
  logic                                norm_r   = 1'b0;
  logic [osp_pkg::TARGET_W-1:0]        target_r = osp_pkg::TARGET_RESET;
  logic signed [osp_pkg::SAMPLE_W-1:0] pcm_mem [MAX_SAMPLES];
  logic [14:0]                         pcm_count   = '0;
  logic [15:0]                         pcm_peak    = '0;
  logic [osp_pkg::GAIN_W-1:0]          gain_q      = osp_pkg::UNITY_GAIN;
  logic [30:0]                         play_pos    = '0;
  logic [14:0]                         play_idx    = '0;
  logic                                play_done   = 1'b0;
  logic signed [osp_pkg::SAMPLE_W-1:0] held_sample = '0;

  player_cmd_t   player_cmds[$];
  osp_pkg::out_t sample_outs_due[$];
  bit            calm_flag = 1'b0;
  int            n_items   = 0;
  int            errs      = 0;
  int            gap_left  = 0;
  int            quiet     = 0;
  int            stall_cnt = 0;
  logic          drv_start;
  logic          drv_we;
  osp_pkg::out_t want;

  function automatic logic signed [osp_pkg::SAMPLE_W-1:0] apply_gain(
      logic signed [osp_pkg::SAMPLE_W-1:0] s, logic [osp_pkg::GAIN_W-1:0] g);
    longint prod;
    longint maxv;
    maxv = (longint'(1) << (osp_pkg::SAMPLE_W - 1)) - 1;
    prod = (longint'(s) * longint'(g)) >>> osp_pkg::FRAC_W;
    if (prod > maxv) prod = maxv;
    if (prod < -maxv - 1) prod = -maxv - 1;
    return osp_pkg::SAMPLE_W'(prod);
  endfunction

  function automatic void set_register(osp_pkg::cfg_e idx,
                                       logic [osp_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      osp_pkg::CFG_RATE:   rate_r   = data[osp_pkg::RATE_W-1:0];
      osp_pkg::CFG_NORM:   norm_r   = data[0];
      osp_pkg::CFG_TARGET: target_r = data[osp_pkg::TARGET_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic osp_pkg::out_t play_item(osp_pkg::in_t it);
    int            mag;
    logic [31:0]   pos_sum;
    logic [31:0]   stop_pos;
    logic [14:0]   idx;
    logic [13:0]   rd_idx;
    osp_pkg::out_t r;
    case (osp_pkg::op_e'(it.operation))
      osp_pkg::OP_CLEAR: begin
        pcm_count = '0;
        pcm_peak  = '0;
      end
      osp_pkg::OP_LOAD: begin
        if (pcm_count < MAX_SAMPLES) begin
          mag = int'($signed(it.sample_in));
          pcm_mem[pcm_count[13:0]] = it.sample_in;
          pcm_count = pcm_count + 15'd1;
          if (mag < 0) mag = -mag;
          if (mag > int'(pcm_peak)) pcm_peak = 16'(mag);
        end
      end
      osp_pkg::OP_REWIND: begin
        play_pos    = '0;
        play_idx    = '0;
        play_done   = 1'b0;
        held_sample = '0;
        if (!norm_r) gain_q = osp_pkg::UNITY_GAIN;
        else if (pcm_peak == 0) gain_q = '0;
        else gain_q = osp_pkg::GAIN_W'((longint'(target_r) << osp_pkg::FRAC_W) /
                                       longint'(pcm_peak));
      end
      default: begin
        if (!play_done) begin
          stop_pos = {1'b0, pcm_count, 16'd0};
          pos_sum  = {1'b0, play_pos} + {8'd0, rate_r};
          if (pos_sum >= stop_pos) begin
            play_pos  = (pcm_count != 0) ? {pcm_count - 15'd1, 16'd0} : '0;
            play_done = 1'b1;
          end else begin
            play_pos = pos_sum[30:0];
            idx      = pos_sum[30:16];
            if (idx > play_idx) begin
              rd_idx      = 14'(idx - 15'd1);
              held_sample = apply_gain(pcm_mem[rd_idx], gain_q);
              play_idx    = idx;
            end
          end
        end
      end
    endcase
    r.out_sample = held_sample;
    r.done_res   = play_done;
    return r;
  endfunction

  task automatic push_op(osp_pkg::op_e op, logic [osp_pkg::SAMPLE_W-1:0] s);
    player_cmd_t c;
    c.is_cfg = 1'b0;
    c.calm   = calm_flag;
    c.idx    = osp_pkg::CFG_RATE;
    c.data   = '0;
    c.item.operation = op;
    c.item.sample_in = s;
    player_cmds.push_back(c);
    n_items++;
  endtask

  task automatic set_phase(logic [osp_pkg::RATE_W-1:0] rate, logic norm,
                           logic [osp_pkg::TARGET_W-1:0] tgt);
    player_cmd_t c;
    c.is_cfg = 1'b1;
    c.calm   = 1'b0;
    c.item   = '0;
    c.idx  = osp_pkg::CFG_RATE;
    c.data = osp_pkg::CFG_DATA_W'(rate);
    player_cmds.push_back(c);
    c.idx  = osp_pkg::CFG_NORM;
    c.data = osp_pkg::CFG_DATA_W'(norm);
    player_cmds.push_back(c);
    c.idx  = osp_pkg::CFG_TARGET;
    c.data = osp_pkg::CFG_DATA_W'(tgt);
    player_cmds.push_back(c);
  endtask

  function automatic logic [osp_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i    <= 1'b0;
      in_i       <= '0;
      cfg_we_i   <= 1'b0;
      cfg_idx_i  <= '0;
      cfg_data_i <= '0;
      gap_left   = 0;
      quiet      = 0;
    end else begin
      drv_start = start_i;
      drv_we    = 1'b0;
      if (start_i && !busy_o) begin
        sample_outs_due.push_back(play_item(in_i));
        void'(player_cmds.pop_front());
        drv_start = 1'b0;
      end
      if (!drv_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (player_cmds.size() > 0 && !cfg_we_i) begin
          if (player_cmds[0].is_cfg) begin
            if (sample_outs_due.size() == 0 && !busy_o && quiet >= SETTLE_CYCLES) begin
              set_register(player_cmds[0].idx, player_cmds[0].data);
              drv_we = 1'b1;
              cfg_idx_i  <= player_cmds[0].idx;
              cfg_data_i <= player_cmds[0].data;
              void'(player_cmds.pop_front());
            end
          end else if (!player_cmds[0].calm && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(0, 3);
          end else begin
            drv_start = 1'b1;
            in_i <= player_cmds[0].item;
          end
        end
      end
      quiet = (sample_outs_due.size() == 0 && !busy_o) ? quiet + 1 : 0;
      start_i  <= drv_start;
      cfg_we_i <= drv_we;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (sample_outs_due.size() == 0) begin
        $error("unexpected result: out_sample %0d done_res %0b",
               $signed(res_o.out_sample), res_o.done_res);
        errs++;
      end else begin
        want = sample_outs_due.pop_front();
        if (res_o.out_sample !== want.out_sample) begin
          $error("out_sample expected %0d actual %0d",
                 $signed(want.out_sample), $signed(res_o.out_sample));
          errs++;
        end
        if (res_o.done_res !== want.done_res) begin
          $error("done_res expected %0b actual %0b", want.done_res, res_o.done_res);
          errs++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_valid_o || cfg_we_i) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    logic [osp_pkg::RATE_W-1:0]   r;
    logic [osp_pkg::TARGET_W-1:0] tgt;
    int                           nload;
    longint                       nticks;
    int                           base;

    // reset register values: empty store, then unity playback at rate 1.0
    push_op(osp_pkg::OP_TICK, 16'h0000);
    push_op(osp_pkg::OP_TICK, 16'hFFFF);
    push_op(osp_pkg::OP_REWIND, 16'h0000);
    push_op(osp_pkg::OP_LOAD, 16'h8000);
    push_op(osp_pkg::OP_LOAD, 16'h7FFF);
    push_op(osp_pkg::OP_LOAD, 16'h0000);
    push_op(osp_pkg::OP_LOAD, 16'hFFFF);
    push_op(osp_pkg::OP_LOAD, 16'h0001);
    push_op(osp_pkg::OP_REWIND, 16'h5555);
    repeat (6) push_op(osp_pkg::OP_TICK, 16'hAAAA);
    push_op(osp_pkg::OP_CLEAR, 16'h1234);

    // normalize a small peak into saturation, then a zero peak
    set_phase(24'h018000, 1'b1, osp_pkg::TARGET_RESET);
    push_op(osp_pkg::OP_CLEAR, 16'h0000);
    push_op(osp_pkg::OP_LOAD, 16'd100);
    push_op(osp_pkg::OP_LOAD, 16'hFFFD);
    push_op(osp_pkg::OP_LOAD, 16'hFF9C);
    push_op(osp_pkg::OP_REWIND, 16'h0000);
    repeat (3) push_op(osp_pkg::OP_TICK, 16'h0000);
    push_op(osp_pkg::OP_CLEAR, 16'h0000);
    push_op(osp_pkg::OP_REWIND, 16'h0000);
    push_op(osp_pkg::OP_LOAD, 16'd5);
    push_op(osp_pkg::OP_TICK, 16'h0000);

    // play a short sound at the top rate
    set_phase(24'hFFFFFF, 1'b0, '0);
    push_op(osp_pkg::OP_CLEAR, 16'h0000);
    repeat (24) push_op(osp_pkg::OP_LOAD, pick_sample());
    push_op(osp_pkg::OP_REWIND, 16'h0000);
    repeat (8) push_op(osp_pkg::OP_TICK, 16'($urandom));

    base = n_items;
    while (n_items < base + RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       r = '0;
        1:       r = 24'hFFFFFF;
        2:       r = 24'd1;
        3:       r = 24'($urandom);
        default: r = 24'($urandom_range(24'h002000, 24'h030000));
      endcase
      case ($urandom_range(0, 5))
        0:       tgt = '0;
        1:       tgt = osp_pkg::TARGET_RESET;
        default: tgt = 15'($urandom);
      endcase
      set_phase(r, 1'($urandom), tgt);
      calm_flag = (n_items > base + RAND_ITEMS - CALM_ITEMS);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(4, 12)) begin
          push_op(osp_pkg::op_e'($urandom_range(0, 3)), 16'($urandom));
        end
      end else begin
        if ($urandom_range(0, 5) != 0) push_op(osp_pkg::OP_CLEAR, 16'($urandom));
        nload = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 16);
        repeat (nload) begin
          if ($urandom_range(0, 15) == 0) begin
            push_op(osp_pkg::op_e'($urandom_range(0, 3)), 16'($urandom));
          end
          push_op(osp_pkg::OP_LOAD, pick_sample());
        end
        push_op(osp_pkg::OP_REWIND, 16'($urandom));
        if (r == 0) nticks = 6;
        else nticks = (longint'(nload) << osp_pkg::FRAC_W) / longint'(r) + 3;
        if (nticks > 40) nticks = 40;
        repeat (nticks) begin
          if ($urandom_range(0, 19) == 0) begin
            push_op(osp_pkg::op_e'($urandom_range(0, 3)), 16'($urandom));
          end
          push_op(osp_pkg::OP_TICK, 16'($urandom));
        end
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (player_cmds.size() != 0 || sample_outs_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errs == 0 && sample_outs_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
